// ===== rtl/core/auf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// auf_pkg
// Shared constants and types of the advertising-data UUID128 filter.
// ----------------------------------------------------------------------------
package auf_pkg;

    localparam int unsigned UUID_BYTES  = 16;
    localparam int unsigned UUID_WIDTH  = 8 * UUID_BYTES;
    localparam int unsigned OFFS_WIDTH  = $clog2(UUID_BYTES) + 1;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 64;

    localparam logic [7:0] TYPE_UUID128_PARTIAL = 8'h06;
    localparam logic [7:0] TYPE_UUID128_FULL    = 8'h07;

    localparam logic [CFG_IDX_W-1:0] REG_UUID_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_UUID_HIGH = 1'b1;

    typedef logic [UUID_WIDTH-1:0] uuid_t;

endpackage

// ===== rtl/core/auf_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// auf_if
// Valid/ready channels of the filter: payload bytes, results, register writes.
// ----------------------------------------------------------------------------
interface auf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       is_last;

    modport source (output valid, output payload_byte, output is_last, input ready);
    modport sink   (input valid, input payload_byte, input is_last, output ready);
endinterface

interface auf_out_if;
    logic valid;
    logic ready;
    logic service_found;

    modport source (output valid, output service_found, input ready);
    modport sink   (input valid, input service_found, output ready);
endinterface

interface auf_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [auf_pkg::CFG_IDX_W-1:0]  index;
    logic [auf_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/ad_struct_uuid_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ad_struct_uuid_filter
// Scans advertising payloads for a 128-bit service UUID list naming a target.
// ----------------------------------------------------------------------------
//  channel | dir | carries                       | request ends with
//  in_ch   | in  | payload_byte, is_last         | is_last = 1
//  out_ch  | out | service_found                 | one per payload
//  cfg     | in  | index, data (uuid_low / high) | always ready
//
//  One payload byte a cycle; the result leaves through a single output
//  register in the cycle after the final byte is taken.
//  in_ch stalls only while a result waits in out_ch and out_ch is not ready.
//  Reset clears parse state, the result register and both UUID words.
//  Write configuration only while no payload is in progress.
// ----------------------------------------------------------------------------
module ad_struct_uuid_filter (
    input  logic       clk,
    input  logic       rst_n,
    auf_in_if.sink     in_ch,
    auf_out_if.source  out_ch,
    auf_cfg_if.sink    cfg
);
    import auf_pkg::*;

    uuid_t uuid;

    // hold the target UUID
    auf_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .uuid  (uuid)
    );

    // walk the structures, compare, and register the result
    auf_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .uuid   (uuid),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

`ifndef NO_ASSERTIONS
    // a final byte taken always leaves a result waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready && in_ch.is_last |=> out_ch.valid)
        else $error("final byte produced no result");

    // a non-final byte never creates a result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready && !in_ch.is_last
        && (!out_ch.valid || out_ch.ready) |=> !out_ch.valid)
        else $error("result without final byte");

    // a delivered result is not repeated
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.ready && !(in_ch.valid && in_ch.ready && in_ch.is_last)
        |=> !out_ch.valid)
        else $error("result repeated");
`endif

endmodule

// ===== rtl/core/auf_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// auf_cfg_regs
// Target UUID register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module auf_cfg_regs (
    input  logic            clk,
    input  logic            rst_n,
    auf_cfg_if.sink         cfg,
    output auf_pkg::uuid_t  uuid
);
    import auf_pkg::*;

    logic [CFG_DATA_W-1:0] low_reg;
    logic [CFG_DATA_W-1:0] high_reg;

    assign cfg.ready = 1'b1;
    assign uuid      = {high_reg, low_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= '0;
            high_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_UUID_LOW:  low_reg  <= cfg.data;
                REG_UUID_HIGH: high_reg <= cfg.data;
                default:       ;
            endcase
        end
    end

endmodule

// ===== rtl/core/auf_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// auf_parser
// Length/type/data walker with UUID compare and result register.
// ----------------------------------------------------------------------------
module auf_parser (
    input  logic            clk,
    input  logic            rst_n,
    input  auf_pkg::uuid_t  uuid,
    auf_in_if.sink          in_ch,
    auf_out_if.source       out_ch
);
    import auf_pkg::*;

    typedef enum logic [1:0] {
        PH_LENGTH = 2'd0,
        PH_TYPE   = 2'd1,
        PH_BODY   = 2'd2
    } phase_t;

    phase_t                phase_reg,   phase_next;
    logic [7:0]            left_reg,    left_next;
    logic [OFFS_WIDTH-1:0] offs_reg,    offs_next;
    logic                  match_reg,   match_next;
    logic                  found_reg,   found_next;
    logic                  out_vld_reg;
    logic                  out_found_reg;

    logic       accept;
    logic [7:0] left_dec;
    logic [7:0] target;

    assign in_ch.ready          = !out_vld_reg || out_ch.ready;
    assign accept               = in_ch.valid && in_ch.ready;
    assign out_ch.valid         = out_vld_reg;
    assign out_ch.service_found = out_found_reg;

    assign left_dec = left_reg - 8'd1;
    assign target   = uuid[8 * offs_reg[OFFS_WIDTH-2:0] +: 8];

    always_comb
    begin
        phase_next = phase_reg;
        left_next  = left_reg;
        offs_next  = offs_reg;
        match_next = match_reg;
        found_next = found_reg;
        unique case (phase_reg)
            PH_TYPE:
            begin
                left_next  = left_dec;
                match_next = (in_ch.payload_byte == TYPE_UUID128_PARTIAL)
                          || (in_ch.payload_byte == TYPE_UUID128_FULL);
                offs_next  = '0;
                phase_next = (left_dec == 8'd0) ? PH_LENGTH : PH_BODY;
            end
            PH_BODY:
            begin
                // compare only the first sixteen data bytes; the offset holds at 16
                if (!offs_reg[OFFS_WIDTH-1])
                begin
                    match_next = match_reg && (in_ch.payload_byte == target);
                    offs_next  = offs_reg + 1'b1;
                    if (offs_next[OFFS_WIDTH-1] && match_next)
                        found_next = 1'b1;
                end
                left_next = left_dec;
                if (left_dec == 8'd0)
                    phase_next = PH_LENGTH;
            end
            default:
            begin
                // zero length byte: stay on length
                if (in_ch.payload_byte != 8'd0)
                begin
                    left_next  = in_ch.payload_byte;
                    phase_next = PH_TYPE;
                end
                else
                    phase_next = PH_LENGTH;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LENGTH;
            left_reg      <= '0;
            offs_reg      <= '0;
            match_reg     <= 1'b0;
            found_reg     <= 1'b0;
            out_vld_reg   <= 1'b0;
            out_found_reg <= 1'b0;
        end
        else
        begin
            if (out_ch.ready)
                out_vld_reg <= 1'b0;
            if (accept)
            begin
                if (in_ch.is_last)
                begin
                    out_vld_reg   <= 1'b1;
                    out_found_reg <= found_next;
                    phase_reg     <= PH_LENGTH;
                    left_reg      <= '0;
                    offs_reg      <= '0;
                    match_reg     <= 1'b0;
                    found_reg     <= 1'b0;
                end
                else
                begin
                    phase_reg <= phase_next;
                    left_reg  <= left_next;
                    offs_reg  <= offs_next;
                    match_reg <= match_next;
                    found_reg <= found_next;
                end
            end
        end
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stand-alone bench for ad_struct_uuid_filter: drives advertising payloads
// byte by byte, tracks the expected service_found verdict of every payload
// and compares it with what the filter returns.
// ----------------------------------------------------------------------------
module tb;

    import auf_pkg::*;

    typedef enum logic [1:0] {
        SCAN_LENGTH = 2'd0,
        SCAN_TYPE   = 2'd1,
        SCAN_BODY   = 2'd2
    } scan_phase_t;

    // ------------------------------------------------------------------------
    // Verdict tracker: follows the length/type/data walk of each payload and
    // queues the verdict due on its final byte.
    // ------------------------------------------------------------------------
    class uuid_hit_tracker;
        uuid_t       target;
        scan_phase_t phase;
        logic [7:0]  left_in_field;
        logic [4:0]  body_pos;
        logic        matching;
        logic        found;
        logic        verdicts_due[$];
        int          errors;

        function new();
            target = '0;
            errors = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            phase         = SCAN_LENGTH;
            left_in_field = '0;
            body_pos      = '0;
            matching      = 1'b0;
            found         = 1'b0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_UUID_LOW)
                target[63:0] = val;
            else
                target[127:64] = val;
        endfunction

        // Note one accepted request.
        function void take_byte(logic [7:0] b, logic last);
            unique case (phase)
                SCAN_TYPE:
                begin
                    left_in_field = left_in_field - 8'd1;
                    matching = (b == TYPE_UUID128_PARTIAL) || (b == TYPE_UUID128_FULL);
                    body_pos = '0;
                    phase = (left_in_field == 8'd0) ? SCAN_LENGTH : SCAN_BODY;
                end
                SCAN_BODY:
                begin
                    if (body_pos < UUID_BYTES)
                    begin
                        if (b != target[body_pos * 8 +: 8])
                            matching = 1'b0;
                        body_pos = body_pos + 5'd1;
                        if (body_pos == UUID_BYTES && matching)
                            found = 1'b1;
                    end
                    left_in_field = left_in_field - 8'd1;
                    if (left_in_field == 8'd0)
                        phase = SCAN_LENGTH;
                end
                default:
                begin
                    if (b != 8'h00)
                    begin
                        left_in_field = b;
                        phase = SCAN_TYPE;
                    end
                    else
                        phase = SCAN_LENGTH;
                end
            endcase
            if (last)
            begin
                verdicts_due.push_back(found);
                clear_scan();
            end
        endfunction

        // Compare one returned verdict with the oldest one due.
        function void check_verdict(logic got);
            logic want;
            if (verdicts_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: service_found=%b returned with none due", got);
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: service_found expected %b, got %b", want, got);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    auf_in_if  in_ch ();
    auf_out_if out_ch ();
    auf_cfg_if cfg_ch ();

    ad_struct_uuid_filter u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg_ch)
    );

    uuid_hit_tracker sb = new();

    int send_idle_pct  = 0;   // chance in a hundred that the sender idles on each roll
    int recv_stall_pct = 0;   // chance in a hundred that the receiver stalls on each roll
    int bytes_sent     = 0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Generous ceiling: far beyond the slowest legal run under full idling.
    initial
    begin
        #5_000_000;
        $display("[ad_struct_uuid_filter] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: check on every accepted verdict, then roll the next stall.
    // ------------------------------------------------------------------------
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
                sb.check_verdict(out_ch.service_found);
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Offer one payload byte, idling first at random, and hold it until taken.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.payload_byte <= b;
        in_ch.is_last      <= last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.take_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_payload(input logic [7:0] pl[$]);
        foreach (pl[i])
            send_byte(pl[i], i == pl.size() - 1);
    endtask

    // Drop valid and hold off until every verdict has come back, then let
    // the output register settle before anything else happens.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.verdicts_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register write; the trailing wait keeps back-to-back writes from
    // stacking two updates of valid in one step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Payload builder: mostly well-formed structures, UUID list fields that
    // carry the target (sometimes with one spoilt byte), short and long
    // fields, zero-length fields, look-alike data under a wrong type, the odd
    // cut-off payload and some plain noise.
    // ------------------------------------------------------------------------
    function automatic void make_payload(output logic [7:0] pl[$]);
        int         n_fields;
        int         kind;
        int         len;
        int         spoil_at;
        int         cut;
        logic [7:0] flip;
        logic [7:0] type_code;
        pl = {};
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 40))
                pl.push_back(8'($urandom_range(0, 255)));
            return;
        end
        n_fields = $urandom_range(1, 3);
        repeat (n_fields)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
                pl.push_back(8'h00);
            else if (kind <= 6 || kind == 9)
            begin
                if (kind == 6)
                    len = $urandom_range(1, 16);        // too short to match
                else if ($urandom_range(0, 19) == 0)
                    len = $urandom_range(18, 255);      // rare long field
                else
                    len = 17 + $urandom_range(0, 3);
                spoil_at = $urandom_range(0, 47);
                flip     = 8'($urandom_range(1, 255));
                if (kind == 9)
                begin
                    // target bytes under a type that is not a UUID128 list
                    type_code = 8'($urandom_range(0, 255));
                    if (type_code == TYPE_UUID128_PARTIAL || type_code == TYPE_UUID128_FULL)
                        type_code = 8'h16;
                end
                else
                    type_code = $urandom_range(0, 1) ? TYPE_UUID128_FULL : TYPE_UUID128_PARTIAL;
                pl.push_back(len[7:0]);
                pl.push_back(type_code);
                for (int i = 1; i < len; i++)
                begin
                    if (i <= 16)
                        pl.push_back(sb.target[(i - 1) * 8 +: 8]
                                     ^ (((i - 1) == spoil_at) ? flip : 8'h00));
                    else
                        pl.push_back(8'($urandom_range(0, 255)));
                end
            end
            else
            begin
                len = $urandom_range(1, 10);
                pl.push_back(len[7:0]);
                for (int i = 0; i < len; i++)
                    pl.push_back(8'($urandom_range(0, 255)));
            end
        end
        // cut the payload short now and then
        if ($urandom_range(0, 5) == 0)
        begin
            cut = $urandom_range(1, pl.size());
            while (pl.size() > cut)
                void'(pl.pop_back());
        end
    endfunction

    // Load a target, set the idling mix and stream random payloads.
    task automatic run_phase(input int idle_pct, input int stall_pct,
                             input logic [CFG_DATA_W-1:0] uuid_low,
                             input logic [CFG_DATA_W-1:0] uuid_high,
                             input int n_bytes);
        logic [7:0] pl[$];
        int         goal;
        drain();
        write_reg(REG_UUID_LOW, uuid_low);
        write_reg(REG_UUID_HIGH, uuid_high);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        goal = bytes_sent + n_bytes;
        while (bytes_sent < goal)
        begin
            make_payload(pl);
            send_payload(pl);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [7:0] pl[$];

        rst_n              <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.payload_byte <= 8'h00;
        in_ch.is_last      <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= REG_UUID_LOW;
        cfg_ch.data        <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed payloads against the reset target of all zeros.
        // Zero-length field, then a partial UUID list that matches exactly.
        pl = {8'h00, 8'h11, TYPE_UUID128_PARTIAL};
        repeat (16) pl.push_back(8'h00);
        send_payload(pl);
        // Full UUID list too short to hold a UUID.
        pl = {8'h03, TYPE_UUID128_FULL, 8'h00, 8'h00};
        send_payload(pl);
        // Maximum length byte, cut off at once by the final flag.
        pl = {8'hFF};
        send_payload(pl);
        // Lone zero-length byte as the whole payload.
        pl = {8'h00};
        send_payload(pl);

        // Random phases; each one drains and reloads the target first.
        run_phase(0,  0,  {CFG_DATA_W{1'b1}}, {CFG_DATA_W{1'b1}}, 300);
        run_phase(86, 0,  {$urandom, $urandom}, {$urandom, $urandom}, 300);
        run_phase(0,  86, {$urandom, $urandom}, {$urandom, $urandom}, 300);
        run_phase(37, 37, '0, {$urandom, $urandom}, 300);

        drain();
        // A verdict still due at this point counts as a failure too.
        if (sb.errors == 0 && sb.verdicts_due.size() == 0)
            $display("[ad_struct_uuid_filter] OK");
        else
            $display("[ad_struct_uuid_filter] ERROR");
        $finish;
    end

endmodule
